// ----- hw/rtl/lrsm_pkg.sv -----
// Shared constants, codes and helper functions for the lens radial source mapper.
package lrsm_pkg;

    // Field widths and fixed-point formats
    localparam int LRSM_COORD_W          = 24;
    localparam int LRSM_COORD_FRAC_BITS  = 8;
    localparam int LRSM_COEF_W           = 32;
    localparam int LRSM_COEF_FRAC_BITS   = 24;
    localparam int LRSM_NORM_W           = 48;
    localparam int LRSM_NORM_FRAC_BITS   = 46;

    // Magnitudes are clamped to 2^50, so 51 bits hold them
    localparam int LRSM_MAG_W = 51;
    localparam int LRSM_SHQ_W = 80;
    localparam logic [LRSM_MAG_W-1:0] LRSM_MAG_LIMIT = {1'b1, {(LRSM_MAG_W-1){1'b0}}};

    // Shift that takes d2*norm to r2 in coefficient format
    localparam int LRSM_SH_R2 =
        2 * LRSM_COORD_FRAC_BITS + LRSM_NORM_FRAC_BITS - LRSM_COEF_FRAC_BITS;

    // 1.0 in coefficient format
    localparam longint LRSM_ONE = longint'(1) << LRSM_COEF_FRAC_BITS;

    // Reset value of the normaliser: 1.0 in Q2.46
    localparam logic [LRSM_NORM_W-1:0] LRSM_NORM_RESET =
        LRSM_NORM_W'(longint'(1) << LRSM_NORM_FRAC_BITS);

    // Output coordinate range
    localparam longint LRSM_OUT_MAX = (longint'(1) << (LRSM_COORD_W - 1)) - 1;
    localparam longint LRSM_OUT_MIN = -(longint'(1) << (LRSM_COORD_W - 1));

    // Pipeline depth: each split multiplier takes LRSM_MUL_LAT stages
    localparam int LRSM_MUL_LAT = 3;
    localparam int LRSM_STAGES  = 10 + 5 * LRSM_MUL_LAT;

    // Register map, in 64-bit words
    typedef enum logic [2:0] {
        LRSM_REG_K1    = 3'd0,
        LRSM_REG_K2    = 3'd1,
        LRSM_REG_RED   = 3'd2,
        LRSM_REG_BLUE  = 3'd3,
        LRSM_REG_CX    = 3'd4,
        LRSM_REG_CY    = 3'd5,
        LRSM_REG_NORM  = 3'd6
    } t_reg_idx;

    // Channel codes
    typedef enum logic [1:0] {
        LRSM_CH_RED   = 2'd0,
        LRSM_CH_GREEN = 2'd1,
        LRSM_CH_BLUE  = 2'd2,
        LRSM_CH_ALPHA = 2'd3
    } t_channel;

    // Clamp a shifted product magnitude to 2^50
    function automatic logic [LRSM_MAG_W-1:0] sat_mag(input logic [LRSM_SHQ_W-1:0] q);
        return (q > LRSM_SHQ_W'(LRSM_MAG_LIMIT)) ? LRSM_MAG_LIMIT : q[LRSM_MAG_W-1:0];
    endfunction

    // Apply a sign to a clamped magnitude
    function automatic logic signed [LRSM_MAG_W:0] apply_sign(
        input logic [LRSM_MAG_W-1:0] m,
        input logic                  neg
    );
        logic signed [LRSM_MAG_W:0] v;
        v = signed'({1'b0, m});
        return neg ? -v : v;
    endfunction

endpackage

// ----- hw/rtl/lrsm_mul.sv -----
// Unsigned multiplier split into four partial products over three register stages.
module lrsm_mul #(
    parameter int WA = 51,
    parameter int WB = 32
) (
    input  logic                             i_clk,
    input  logic [lrsm_pkg::LRSM_MUL_LAT-1:0] i_en,
    input  logic [WA-1:0]                    i_a,
    input  logic [WB-1:0]                    i_b,
    output logic [WA+WB-1:0]                 o_p
);

    localparam int AL  = (WA + 1) / 2;
    localparam int AH  = WA - AL;
    localparam int BL  = (WB + 1) / 2;
    localparam int BH  = WB - BL;
    localparam int WLL = AL + BL;
    localparam int WLH = AL + BH;
    localparam int WHL = AH + BL;
    localparam int WHH = AH + BH;
    localparam int WP  = WA + WB;

    logic [WLL-1:0] r_ll;
    logic [WLH-1:0] r_lh;
    logic [WHL-1:0] r_hl;
    logic [WHH-1:0] r_hh;
    logic [WLL-1:0] r_ll2;
    logic [WHH-1:0] r_hh2;
    logic [WP-1:0]  r_mid;
    logic [WP-1:0]  r_p;

    // Form the four half-width partial products
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ll <= WLL'(i_a[AL-1:0]) * WLL'(i_b[BL-1:0]);
            r_lh <= WLH'(i_a[AL-1:0]) * WLH'(i_b[WB-1:BL]);
            r_hl <= WHL'(i_a[WA-1:AL]) * WHL'(i_b[BL-1:0]);
            r_hh <= WHH'(i_a[WA-1:AL]) * WHH'(i_b[WB-1:BL]);
        end
    end

    // Add the two cross terms at their weights
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_mid <= (WP'(r_lh) << BL) + (WP'(r_hl) << AL);
            r_ll2 <= r_ll;
            r_hh2 <= r_hh;
        end
    end

    // Final sum
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_p <= WP'(r_ll2) + r_mid + (WP'(r_hh2) << (AL + BL));
        end
    end

    assign o_p = r_p;

endmodule

// ----- hw/rtl/lens_radial_source_mapper_top.sv -----
// Lens radial source mapper: pipelined destination-to-source coordinate mapping.
//
// Each transfer on the input side carries one destination coordinate and a channel
// code; exactly one source coordinate leaves for it, in order. A new coordinate is
// taken in every cycle while the output side does not stall. The depth comes from
// the chain of five dependent products (r2, r4 with k1*r2, k2*r4, channel scale,
// offset), each built by a multiplier split into partial products over three
// register stages, plus the subtract, square, sum, clamp and final add stages
// around them. Every stage carries its own valid bit and advances when the stage
// after it can take its contents, so bubbles close up under a stall and the input
// stays ready while a finished result waits, until every stage holds a coordinate.
// Registers sit on an APB-style port at byte address 8*index and are meant to be
// written only while the pipeline is empty; there is no start-up clearing pass.
module lens_radial_source_mapper_top (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // Register port
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [5:0]                                paddr,
    input  logic [63:0]                               pwdata,
    output logic [63:0]                               prdata,
    output logic                                      pready,
    // Destination coordinates
    input  logic                                      i_in_valid,
    output logic                                      o_in_ready,
    input  logic signed [lrsm_pkg::LRSM_COORD_W-1:0]  i_dst_x,
    input  logic signed [lrsm_pkg::LRSM_COORD_W-1:0]  i_dst_y,
    input  logic [1:0]                                i_channel,
    // Source coordinates
    output logic                                      o_out_valid,
    input  logic                                      i_out_ready,
    output logic signed [lrsm_pkg::LRSM_COORD_W-1:0]  o_src_x,
    output logic signed [lrsm_pkg::LRSM_COORD_W-1:0]  o_src_y,
    output logic                                      o_saturated
);

    localparam int L       = lrsm_pkg::LRSM_MUL_LAT;
    localparam int NSTG    = lrsm_pkg::LRSM_STAGES;
    localparam int MW      = lrsm_pkg::LRSM_MAG_W;
    localparam int CW      = lrsm_pkg::LRSM_COORD_W;
    localparam int KW      = lrsm_pkg::LRSM_COEF_W;
    localparam int NW      = lrsm_pkg::LRSM_NORM_W;
    localparam int QW      = lrsm_pkg::LRSM_SHQ_W;
    localparam int C       = lrsm_pkg::LRSM_COEF_FRAC_BITS;
    localparam int DW      = CW + 1;
    localparam int D2W     = 2 * DW;

    // Stage numbers
    localparam int S_IN    = 0;
    localparam int S_SQ    = 1;
    localparam int S_D2    = 2;
    localparam int S_M1    = 3;
    localparam int S_R2    = S_M1 + L;
    localparam int S_M2    = S_R2 + 1;
    localparam int S_R4    = S_M2 + L;
    localparam int S_M3    = S_R4 + 1;
    localparam int S_T2    = S_M3 + L;
    localparam int S_POLY  = S_T2 + 1;
    localparam int S_M4    = S_POLY + 1;
    localparam int S_SCL   = S_M4 + L;
    localparam int S_M5    = S_SCL + 1;
    localparam int S_OFF   = S_M5 + L;
    localparam int S_OUT   = S_OFF + 1;

    localparam logic signed [MW+2:0] PLIM    = (MW+3)'(lrsm_pkg::LRSM_MAG_LIMIT);
    localparam logic signed [MW+1:0] OUT_MAX = (MW+2)'(lrsm_pkg::LRSM_OUT_MAX);
    localparam logic signed [MW+1:0] OUT_MIN = (MW+2)'(lrsm_pkg::LRSM_OUT_MIN);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [KW-1:0] r_k1;
    logic signed [KW-1:0] r_k2;
    logic signed [KW-1:0] r_red;
    logic signed [KW-1:0] r_blue;
    logic signed [CW-1:0] r_cx;
    logic signed [CW-1:0] r_cy;
    logic [NW-1:0]        r_norm;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Write a register at the access phase; drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1   <= '0;
            r_k2   <= '0;
            r_red  <= '0;
            r_blue <= '0;
            r_cx   <= '0;
            r_cy   <= '0;
            r_norm <= lrsm_pkg::LRSM_NORM_RESET;
        end else if (cfg_wr) begin
            case (paddr[5:3])
                lrsm_pkg::LRSM_REG_K1:   r_k1   <= pwdata[KW-1:0];
                lrsm_pkg::LRSM_REG_K2:   r_k2   <= pwdata[KW-1:0];
                lrsm_pkg::LRSM_REG_RED:  r_red  <= pwdata[KW-1:0];
                lrsm_pkg::LRSM_REG_BLUE: r_blue <= pwdata[KW-1:0];
                lrsm_pkg::LRSM_REG_CX:   r_cx   <= pwdata[CW-1:0];
                lrsm_pkg::LRSM_REG_CY:   r_cy   <= pwdata[CW-1:0];
                lrsm_pkg::LRSM_REG_NORM: r_norm <= pwdata[NW-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (paddr[5:3])
            lrsm_pkg::LRSM_REG_K1:   prdata = {32'b0, r_k1};
            lrsm_pkg::LRSM_REG_K2:   prdata = {32'b0, r_k2};
            lrsm_pkg::LRSM_REG_RED:  prdata = {32'b0, r_red};
            lrsm_pkg::LRSM_REG_BLUE: prdata = {32'b0, r_blue};
            lrsm_pkg::LRSM_REG_CX:   prdata = {40'b0, r_cx};
            lrsm_pkg::LRSM_REG_CY:   prdata = {40'b0, r_cy};
            lrsm_pkg::LRSM_REG_NORM: prdata = {16'b0, r_norm};
            default:                 prdata = '0;
        endcase
    end

    // Sign and magnitude of the coefficients and channel factors, kept registered
    logic [KW-1:0]        r_k1_mag, r_k2_mag, r_red_mag, r_blue_mag;
    logic                 r_k1_neg, r_k2_neg, r_red_neg, r_blue_neg;
    logic signed [KW:0]   w_chr, w_chb;

    assign w_chr = (KW+1)'(lrsm_pkg::LRSM_ONE) + (KW+1)'(r_red);
    assign w_chb = (KW+1)'(lrsm_pkg::LRSM_ONE) + (KW+1)'(r_blue);

    always_ff @(posedge i_clk) begin
        r_k1_neg   <= r_k1[KW-1];
        r_k1_mag   <= r_k1[KW-1] ? KW'(-r_k1) : r_k1;
        r_k2_neg   <= r_k2[KW-1];
        r_k2_mag   <= r_k2[KW-1] ? KW'(-r_k2) : r_k2;
        r_red_neg  <= w_chr[KW];
        r_red_mag  <= w_chr[KW] ? KW'(-w_chr) : w_chr[KW-1:0];
        r_blue_neg <= w_chb[KW];
        r_blue_mag <= w_chb[KW] ? KW'(-w_chb) : w_chb[KW-1:0];
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage advances when empty or when its successor advances
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] n_vld;

    assign en[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
    for (genvar s = 0; s < NSTG - 1; s++) begin : g_en
        assign en[s] = !r_vld[s] || en[s+1];
    end

    assign n_vld = {r_vld[NSTG-2:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (en & n_vld) | (~en & r_vld);
        end
    end

    assign o_in_ready  = en[S_IN];
    assign o_out_valid = r_vld[S_OUT];

    // ------------------------------------------------------------------
    // Side data carried down the pipeline
    // ------------------------------------------------------------------
    logic [DW-1:0]       r_mx [S_IN:S_SCL];
    logic [DW-1:0]       r_my [S_IN:S_SCL];
    logic                r_sx [S_IN:S_OFF-1];
    logic                r_sy [S_IN:S_OFF-1];
    logic [1:0]          r_ch [S_IN:S_T2];
    logic signed [MW:0]  r_t1 [S_R4:S_T2-1];
    logic                r_sneg [S_POLY:S_OFF-1];

    for (genvar s = S_IN + 1; s <= S_SCL; s++) begin : g_mag
        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_mx[s] <= r_mx[s-1];
                r_my[s] <= r_my[s-1];
            end
        end
    end

    for (genvar s = S_IN + 1; s <= S_OFF - 1; s++) begin : g_sgn
        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_sx[s] <= r_sx[s-1];
                r_sy[s] <= r_sy[s-1];
            end
        end
    end

    for (genvar s = S_IN + 1; s <= S_T2; s++) begin : g_ch
        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_ch[s] <= r_ch[s-1];
            end
        end
    end

    for (genvar s = S_R4 + 1; s <= S_T2 - 1; s++) begin : g_t1
        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_t1[s] <= r_t1[s-1];
            end
        end
    end

    for (genvar s = S_POLY + 1; s <= S_OFF - 1; s++) begin : g_sneg
        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_sneg[s] <= r_sneg[s-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Offset from the optical centre, as sign and magnitude
    // ------------------------------------------------------------------
    logic signed [DW-1:0] n_dx, n_dy;

    assign n_dx = DW'(i_dst_x) - DW'(r_cx);
    assign n_dy = DW'(i_dst_y) - DW'(r_cy);

    always_ff @(posedge i_clk) begin
        if (en[S_IN]) begin
            r_sx[S_IN] <= n_dx[DW-1];
            r_mx[S_IN] <= n_dx[DW-1] ? DW'(-n_dx) : n_dx;
            r_sy[S_IN] <= n_dy[DW-1];
            r_my[S_IN] <= n_dy[DW-1] ? DW'(-n_dy) : n_dy;
            r_ch[S_IN] <= i_channel;
        end
    end

    // Square both offsets
    logic [D2W-1:0] r_dx2, r_dy2, r_d2;

    always_ff @(posedge i_clk) begin
        if (en[S_SQ]) begin
            r_dx2 <= D2W'(r_mx[S_IN]) * D2W'(r_mx[S_IN]);
            r_dy2 <= D2W'(r_my[S_IN]) * D2W'(r_my[S_IN]);
        end
    end

    // Squared distance
    always_ff @(posedge i_clk) begin
        if (en[S_D2]) begin
            r_d2 <= r_dx2 + r_dy2;
        end
    end

    // ------------------------------------------------------------------
    // r2 = d2 * norm
    // ------------------------------------------------------------------
    logic [D2W+NW-1:0] p_r2;
    logic [MW-1:0]     r_r2;

    lrsm_mul #(.WA(D2W), .WB(NW)) u_mul_r2 (
        .i_clk (i_clk),
        .i_en  (en[S_R2-1:S_M1]),
        .i_a   (r_d2),
        .i_b   (r_norm),
        .o_p   (p_r2)
    );

    always_ff @(posedge i_clk) begin
        if (en[S_R2]) begin
            r_r2 <= lrsm_pkg::sat_mag(QW'(p_r2 >> lrsm_pkg::LRSM_SH_R2));
        end
    end

    // ------------------------------------------------------------------
    // r4 = r2 * r2 and k1 term, side by side
    // ------------------------------------------------------------------
    logic [2*MW-1:0]  p_r4;
    logic [MW+KW-1:0] p_t1;
    logic [MW-1:0]    r_r4;

    lrsm_mul #(.WA(MW), .WB(MW)) u_mul_r4 (
        .i_clk (i_clk),
        .i_en  (en[S_R4-1:S_M2]),
        .i_a   (r_r2),
        .i_b   (r_r2),
        .o_p   (p_r4)
    );

    lrsm_mul #(.WA(MW), .WB(KW)) u_mul_k1 (
        .i_clk (i_clk),
        .i_en  (en[S_R4-1:S_M2]),
        .i_a   (r_r2),
        .i_b   (r_k1_mag),
        .o_p   (p_t1)
    );

    always_ff @(posedge i_clk) begin
        if (en[S_R4]) begin
            r_r4       <= lrsm_pkg::sat_mag(QW'(p_r4 >> C));
            r_t1[S_R4] <= lrsm_pkg::apply_sign(lrsm_pkg::sat_mag(QW'(p_t1 >> C)), r_k1_neg);
        end
    end

    // ------------------------------------------------------------------
    // k2 term, then sum of the two terms
    // ------------------------------------------------------------------
    logic [MW+KW-1:0]     p_t2;
    logic signed [MW:0]   n_t2;
    logic signed [MW+1:0] r_ts;

    lrsm_mul #(.WA(MW), .WB(KW)) u_mul_k2 (
        .i_clk (i_clk),
        .i_en  (en[S_T2-1:S_M3]),
        .i_a   (r_r4),
        .i_b   (r_k2_mag),
        .o_p   (p_t2)
    );

    assign n_t2 = lrsm_pkg::apply_sign(lrsm_pkg::sat_mag(QW'(p_t2 >> C)), r_k2_neg);

    always_ff @(posedge i_clk) begin
        if (en[S_T2]) begin
            r_ts <= (MW+2)'(r_t1[S_T2-1]) + (MW+2)'(n_t2);
        end
    end

    // ------------------------------------------------------------------
    // Polynomial: add one, clamp, split into sign and magnitude; pick channel factor
    // ------------------------------------------------------------------
    logic signed [MW+2:0] n_poly;
    logic [MW-1:0]        n_pmag;
    logic                 n_pneg;
    logic [KW-1:0]        n_cmag;
    logic                 n_cneg;
    logic [MW-1:0]        r_pmag;
    logic [KW-1:0]        r_cmag;

    assign n_poly = (MW+3)'(lrsm_pkg::LRSM_ONE) + (MW+3)'(r_ts);

    always_comb begin
        if (n_poly > PLIM) begin
            n_pmag = lrsm_pkg::LRSM_MAG_LIMIT;
            n_pneg = 1'b0;
        end else if (n_poly < -PLIM) begin
            n_pmag = lrsm_pkg::LRSM_MAG_LIMIT;
            n_pneg = 1'b1;
        end else begin
            n_pneg = n_poly[MW+2];
            n_pmag = n_poly[MW+2] ? MW'(-n_poly) : n_poly[MW-1:0];
        end
    end

    always_comb begin
        case (r_ch[S_T2])
            lrsm_pkg::LRSM_CH_RED: begin
                n_cmag = r_red_mag;
                n_cneg = r_red_neg;
            end
            lrsm_pkg::LRSM_CH_BLUE: begin
                n_cmag = r_blue_mag;
                n_cneg = r_blue_neg;
            end
            lrsm_pkg::LRSM_CH_GREEN, lrsm_pkg::LRSM_CH_ALPHA: begin
                n_cmag = KW'(lrsm_pkg::LRSM_ONE);
                n_cneg = 1'b0;
            end
            default: begin
                n_cmag = KW'(lrsm_pkg::LRSM_ONE);
                n_cneg = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[S_POLY]) begin
            r_pmag         <= n_pmag;
            r_cmag         <= n_cmag;
            r_sneg[S_POLY] <= n_pneg ^ n_cneg;
        end
    end

    // ------------------------------------------------------------------
    // Channel scale
    // ------------------------------------------------------------------
    logic [MW+KW-1:0] p_scl;
    logic [MW-1:0]    r_scl;

    lrsm_mul #(.WA(MW), .WB(KW)) u_mul_scl (
        .i_clk (i_clk),
        .i_en  (en[S_SCL-1:S_M4]),
        .i_a   (r_pmag),
        .i_b   (r_cmag),
        .o_p   (p_scl)
    );

    always_ff @(posedge i_clk) begin
        if (en[S_SCL]) begin
            r_scl <= lrsm_pkg::sat_mag(QW'(p_scl >> C));
        end
    end

    // ------------------------------------------------------------------
    // Scaled offsets
    // ------------------------------------------------------------------
    logic [MW+DW-1:0]    p_ox, p_oy;
    logic signed [MW:0]  r_offx, r_offy;

    lrsm_mul #(.WA(MW), .WB(DW)) u_mul_ox (
        .i_clk (i_clk),
        .i_en  (en[S_OFF-1:S_M5]),
        .i_a   (r_scl),
        .i_b   (r_mx[S_SCL]),
        .o_p   (p_ox)
    );

    lrsm_mul #(.WA(MW), .WB(DW)) u_mul_oy (
        .i_clk (i_clk),
        .i_en  (en[S_OFF-1:S_M5]),
        .i_a   (r_scl),
        .i_b   (r_my[S_SCL]),
        .o_p   (p_oy)
    );

    always_ff @(posedge i_clk) begin
        if (en[S_OFF]) begin
            r_offx <= lrsm_pkg::apply_sign(lrsm_pkg::sat_mag(QW'(p_ox >> C)),
                                           r_sneg[S_OFF-1] ^ r_sx[S_OFF-1]);
            r_offy <= lrsm_pkg::apply_sign(lrsm_pkg::sat_mag(QW'(p_oy >> C)),
                                           r_sneg[S_OFF-1] ^ r_sy[S_OFF-1]);
        end
    end

    // ------------------------------------------------------------------
    // Add back the centre and clip to the coordinate range
    // ------------------------------------------------------------------
    logic signed [MW+1:0] n_vx, n_vy;
    logic signed [CW-1:0] n_src_x, n_src_y;
    logic                 n_clip_x, n_clip_y;
    logic signed [CW-1:0] r_src_x, r_src_y;
    logic                 r_sat;

    assign n_vx = (MW+2)'(r_cx) + (MW+2)'(r_offx);
    assign n_vy = (MW+2)'(r_cy) + (MW+2)'(r_offy);

    always_comb begin
        n_clip_x = 1'b1;
        if (n_vx > OUT_MAX) begin
            n_src_x = CW'(OUT_MAX);
        end else if (n_vx < OUT_MIN) begin
            n_src_x = CW'(OUT_MIN);
        end else begin
            n_src_x  = CW'(n_vx);
            n_clip_x = 1'b0;
        end
    end

    always_comb begin
        n_clip_y = 1'b1;
        if (n_vy > OUT_MAX) begin
            n_src_y = CW'(OUT_MAX);
        end else if (n_vy < OUT_MIN) begin
            n_src_y = CW'(OUT_MIN);
        end else begin
            n_src_y  = CW'(n_vy);
            n_clip_y = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_OUT]) begin
            r_src_x <= n_src_x;
            r_src_y <= n_src_y;
            r_sat   <= n_clip_x || n_clip_y;
        end
    end

    assign o_src_x     = r_src_x;
    assign o_src_y     = r_src_y;
    assign o_saturated = r_sat;

endmodule

// ----- hw/rtl/lrsm_checker.sv -----
// Port-level checks for the lens radial source mapper, bound to its top level.
module lrsm_checker (
    input logic                                      i_clk,
    input logic                                      i_rst_n,
    input logic                                      i_in_valid,
    input logic                                      o_in_ready,
    input logic                                      o_out_valid,
    input logic                                      i_out_ready,
    input logic signed [lrsm_pkg::LRSM_COORD_W-1:0]  o_src_x,
    input logic signed [lrsm_pkg::LRSM_COORD_W-1:0]  o_src_y,
    input logic                                      o_saturated
);

    localparam int NW = $clog2(lrsm_pkg::LRSM_STAGES + 1);
    localparam logic signed [lrsm_pkg::LRSM_COORD_W-1:0] CMAX =
        lrsm_pkg::LRSM_COORD_W'(lrsm_pkg::LRSM_OUT_MAX);
    localparam logic signed [lrsm_pkg::LRSM_COORD_W-1:0] CMIN =
        lrsm_pkg::LRSM_COORD_W'(lrsm_pkg::LRSM_OUT_MIN);

    logic          in_xfer, out_xfer;
    logic [NW-1:0] r_cnt;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = o_out_valid && i_out_ready;

    // Count coordinates taken in but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + NW'(in_xfer) - NW'(out_xfer);
        end
    end

    // No result without a coordinate in flight
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_cnt != '0)
        else $error("result shown with nothing in flight");

    // Never more in flight than the pipeline holds
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(lrsm_pkg::LRSM_STAGES))
        else $error("more coordinates in flight than pipeline stages");

    // An empty pipeline always takes a coordinate
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> o_in_ready)
        else $error("input not ready with empty pipeline");

    // The clip flag only comes with a coordinate at a range limit
    a_sat_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            (o_src_x == CMAX || o_src_x == CMIN || o_src_y == CMAX || o_src_y == CMIN))
        else $error("clip flag set on an in-range coordinate");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_src_x) && $stable(o_src_y) && $stable(o_saturated))
        else $error("stalled result changed");

endmodule

bind lens_radial_source_mapper_top lrsm_checker u_lrsm_checker (.*);
